### rtl/text_console_writer_defines.svh
// Assertion macros shared by the console writer RTL.
// TCW_ASSERT is gated off while rst_n is low; TCW_ASSERT_ALWAYS also checks during reset.
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
`define TCW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("console writer check failed");
`define TCW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("console writer check failed");
`else
`define TCW_ASSERT(lbl, prop)
`define TCW_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### rtl/tcw_pkg.sv
package tcw_pkg;

  // Screen geometry
  localparam int TEXT_COLS  = 80;
  localparam int TEXT_ROWS  = 25;
  localparam int CELL_COUNT = TEXT_COLS * TEXT_ROWS;
  localparam int CELL_AW    = $clog2(CELL_COUNT);
  localparam int CELL_CW    = $clog2(CELL_COUNT + 1);

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;

  // Character and attribute constants
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] BLANK_CODE   = 8'd32;
  localparam logic [7:0] RESET_ATTR   = 8'h0F;

  // Input function codes
  localparam logic [2:0] FUNC_PRINT = 3'd0;
  localparam logic [2:0] FUNC_CLEAR = 3'd1;
  localparam logic [2:0] FUNC_PUT   = 3'd2;
  localparam logic [2:0] FUNC_FILL  = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  // Internal operation codes after classification
  localparam logic [2:0] OP_PRINT   = 3'd0;
  localparam logic [2:0] OP_NEWLINE = 3'd1;
  localparam logic [2:0] OP_CLEAR   = 3'd2;
  localparam logic [2:0] OP_PUT     = 3'd3;
  localparam logic [2:0] OP_FILL    = 3'd4;
  localparam logic [2:0] OP_READ    = 3'd5;
  localparam logic [2:0] OP_NOP     = 3'd6;

  // Classified command handed from front to back
  typedef struct packed {
    logic [2:0]         op;
    logic               ok;     // target cell or row lies on the screen
    logic [7:0]         ch;
    logic [7:0]         attr;
    logic [CELL_AW-1:0] addr;   // cell address, or first cell of the row for fill
  } tcw_cmd_t;

  // Back-end status seen by the front end
  typedef struct packed {
    logic deq;        // back takes the head command this cycle
    logic init_busy;  // clearing pass after reset still running
  } tcw_stat_t;

  // Linear cell address of (row, col)
  function automatic logic [CELL_AW-1:0] cell_addr(input logic [4:0] r, input logic [6:0] c);
    cell_addr = CELL_AW'(r) * CELL_AW'(TEXT_COLS) + CELL_AW'(c);
  endfunction

endpackage

### rtl/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/tcw_front.sv
`include "text_console_writer_defines.svh"

module tcw_front import tcw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [2:0] in_func,
  input  logic [7:0] in_char_code,
  input  logic [6:0] in_col,
  input  logic [4:0] in_row,
  input  logic [3:0] in_fg,
  input  logic [3:0] in_bg,
  output logic       cmd_valid,
  output tcw_cmd_t   cmd,
  input  tcw_stat_t  stat
);

  localparam int QAW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int QCW = $clog2(CMDQ_DEPTH + 1);

  tcw_cmd_t         q_r [CMDQ_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  tcw_cmd_t         cls;
  logic             col_ok, row_ok, push;

  // Classify the incoming item
  always_comb begin
    col_ok   = {1'b0, in_col} < 8'(TEXT_COLS);
    row_ok   = {1'b0, in_row} < 6'(TEXT_ROWS);
    cls.ch   = in_char_code;
    cls.attr = {in_bg, in_fg};
    cls.addr = cell_addr(in_row, in_col);
    cls.ok   = col_ok && row_ok;
    unique case (in_func)
      FUNC_PRINT: cls.op = (in_char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PRINT;
      FUNC_CLEAR: cls.op = OP_CLEAR;
      FUNC_PUT:   cls.op = OP_PUT;
      FUNC_FILL: begin
        cls.op   = OP_FILL;
        cls.ok   = row_ok;
        cls.addr = cell_addr(in_row, 7'd0);
      end
      FUNC_READ:  cls.op = OP_READ;
      default:    cls.op = OP_NOP;
    endcase
  end

  // Queue control
  assign in_full   = (cnt_r == QCW'(CMDQ_DEPTH)) || stat.init_busy;
  assign push      = in_push && !in_full;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (stat.deq) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push && !stat.deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (stat.deq && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

  `TCW_ASSERT_ALWAYS(a_full_after_reset, !rst_n |=> in_full)
  `TCW_ASSERT(a_no_deq_when_empty, stat.deq |-> cmd_valid)

endmodule

### rtl/tcw_back.sv
`include "text_console_writer_defines.svh"

module tcw_back import tcw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  tcw_cmd_t   cmd,
  output tcw_stat_t  stat,
  input  logic       cfg_we,
  input  logic [7:0] cfg_text_attr,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [6:0] out_cursor_x,
  output logic [4:0] out_cursor_y,
  output logic [7:0] out_cell_char,
  output logic [7:0] out_cell_attr
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SWEEP  = 2'd1;
  localparam logic [1:0] S_SCROLL = 2'd2;
  localparam logic [1:0] S_READ   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic               init_r, init_nxt;
  logic [6:0]         cur_col_r, cur_col_nxt;
  logic [4:0]         cur_row_r, cur_row_nxt;
  logic [7:0]         attr_r;
  logic [CELL_AW-1:0] sw_addr_r, sw_addr_nxt;
  logic [CELL_CW-1:0] sw_left_r, sw_left_nxt;
  logic [15:0]        sw_data_r, sw_data_nxt;
  logic [CELL_CW-1:0] src_r, src_nxt;
  logic [CELL_AW-1:0] wr_addr_r, wr_addr_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [6:0]         out_x_r, out_x_nxt;
  logic [4:0]         out_y_r, out_y_nxt;
  logic [7:0]         out_char_r, out_char_nxt;
  logic [7:0]         out_attr_r, out_attr_nxt;

  logic               ram_we;
  logic [CELL_AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]        ram_wdata, ram_rdata;

  logic               slot_free, deq, emit, adv_row;
  logic [7:0]         emit_char, emit_attr;
  logic [7:0]         col_inc;
  logic [5:0]         row_inc;
  logic [CELL_AW-1:0] cur_addr;

  tcw_ram #(.WIDTH(16), .DEPTH(CELL_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign slot_free      = !out_valid_r || out_pop;
  assign deq            = (state_r == S_IDLE) && cmd_valid && slot_free;
  assign stat.deq       = deq;
  assign stat.init_busy = init_r;
  assign cur_addr       = cell_addr(cur_row_r, cur_col_r);
  assign col_inc        = {1'b0, cur_col_r} + 8'd1;
  assign row_inc        = {1'b0, cur_row_r} + 6'd1;

  // Command execution
  always_comb begin
    state_nxt   = state_r;
    init_nxt    = init_r;
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    sw_addr_nxt = sw_addr_r;
    sw_left_nxt = sw_left_r;
    sw_data_nxt = sw_data_r;
    src_nxt     = src_r;
    wr_addr_nxt = wr_addr_r;
    pend_nxt    = pend_r;
    ram_we      = 1'b0;
    ram_waddr   = sw_addr_r;
    ram_wdata   = sw_data_r;
    ram_raddr   = cmd.addr;
    emit        = 1'b0;
    emit_char   = 8'd0;
    emit_attr   = 8'd0;
    adv_row     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (deq) begin
          unique case (cmd.op)
            OP_PRINT: begin
              ram_we    = 1'b1;
              ram_waddr = cur_addr;
              ram_wdata = {attr_r, cmd.ch};
              if (col_inc == 8'(TEXT_COLS)) begin
                cur_col_nxt = 7'd0;
                adv_row     = 1'b1;
              end else begin
                cur_col_nxt = col_inc[6:0];
                emit        = 1'b1;
              end
            end
            OP_NEWLINE: begin
              cur_col_nxt = 7'd0;
              adv_row     = 1'b1;
            end
            OP_CLEAR: begin
              cur_col_nxt = 7'd0;
              cur_row_nxt = 5'd0;
              sw_addr_nxt = '0;
              sw_left_nxt = CELL_CW'(CELL_COUNT);
              sw_data_nxt = {attr_r, BLANK_CODE};
              state_nxt   = S_SWEEP;
            end
            OP_PUT: begin
              ram_we    = cmd.ok;
              ram_waddr = cmd.addr;
              ram_wdata = {cmd.attr, cmd.ch};
              emit      = 1'b1;
            end
            OP_FILL: begin
              if (cmd.ok) begin
                sw_addr_nxt = cmd.addr;
                sw_left_nxt = CELL_CW'(TEXT_COLS);
                sw_data_nxt = {cmd.attr, cmd.ch};
                state_nxt   = S_SWEEP;
              end else begin
                emit = 1'b1;
              end
            end
            OP_READ: begin
              if (cmd.ok) begin
                state_nxt = S_READ;
              end else begin
                emit = 1'b1;
              end
            end
            default: emit = 1'b1;
          endcase
          // Row advance; passing the bottom row starts a scroll
          if (adv_row) begin
            if (row_inc == 6'(TEXT_ROWS)) begin
              src_nxt   = CELL_CW'(TEXT_COLS);
              pend_nxt  = 1'b0;
              state_nxt = S_SCROLL;
            end else begin
              cur_row_nxt = row_inc[4:0];
              emit        = 1'b1;
            end
          end
        end
      end
      S_SWEEP: begin
        ram_we      = 1'b1;
        sw_addr_nxt = sw_addr_r + 1'b1;
        sw_left_nxt = sw_left_r - 1'b1;
        if (sw_left_r == CELL_CW'(1)) begin
          state_nxt = S_IDLE;
          if (init_r) begin
            init_nxt = 1'b0;
          end else begin
            emit = 1'b1;
          end
        end
      end
      S_SCROLL: begin
        // Read one row below, write the cell read last cycle
        ram_we    = pend_r;
        ram_waddr = wr_addr_r;
        ram_wdata = ram_rdata;
        ram_raddr = src_r[CELL_AW-1:0];
        if (src_r != CELL_CW'(CELL_COUNT)) begin
          pend_nxt    = 1'b1;
          wr_addr_nxt = CELL_AW'(src_r - CELL_CW'(TEXT_COLS));
          src_nxt     = src_r + 1'b1;
        end else begin
          pend_nxt    = 1'b0;
          sw_addr_nxt = CELL_AW'(CELL_COUNT - TEXT_COLS);
          sw_left_nxt = CELL_CW'(TEXT_COLS);
          sw_data_nxt = {attr_r, BLANK_CODE};
          state_nxt   = S_SWEEP;
        end
      end
      S_READ: begin
        emit      = 1'b1;
        emit_char = ram_rdata[7:0];
        emit_attr = ram_rdata[15:8];
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_pop;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_char_nxt  = out_char_r;
    out_attr_nxt  = out_attr_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = cur_col_nxt;
      out_y_nxt     = cur_row_nxt;
      out_char_nxt  = emit_char;
      out_attr_nxt  = emit_attr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      init_r      <= 1'b1;
      cur_col_r   <= 7'd0;
      cur_row_r   <= 5'd0;
      attr_r      <= RESET_ATTR;
      sw_addr_r   <= '0;
      sw_left_r   <= CELL_CW'(CELL_COUNT);
      sw_data_r   <= {RESET_ATTR, BLANK_CODE};
      src_r       <= '0;
      wr_addr_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      if (cfg_we) begin
        attr_r <= cfg_text_attr;
      end
      sw_addr_r   <= sw_addr_nxt;
      sw_left_r   <= sw_left_nxt;
      sw_data_r   <= sw_data_nxt;
      src_r       <= src_nxt;
      wr_addr_r   <= wr_addr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
  end

  assign out_empty     = !out_valid_r;
  assign out_cursor_x  = out_x_r;
  assign out_cursor_y  = out_y_r;
  assign out_cell_char = out_char_r;
  assign out_cell_attr = out_attr_r;

  `TCW_ASSERT(a_wr_in_range, ram_we |-> ({1'b0, ram_waddr} < (CELL_AW + 1)'(CELL_COUNT)))
  `TCW_ASSERT(a_cursor_on_screen,
    ({1'b0, cur_col_r} < 8'(TEXT_COLS)) && ({1'b0, cur_row_r} < 6'(TEXT_ROWS)))
  `TCW_ASSERT(a_deq_needs_slot, deq |-> (!out_valid_r || out_pop))
  `TCW_ASSERT(a_no_result_in_init, init_r |-> !emit)

endmodule

### rtl/text_console_writer.sv
// Text console writer: a TEXT_ROWS x TEXT_COLS screen of {attribute, character} cells
// held in one single-port-write RAM, with a cursor. Items enter a two-deep command
// queue (in_push/in_full) and results leave through a one-entry result register
// (out_empty/out_pop); one result per item, in order. Items are executed one at a time,
// one RAM write per cycle. An on-screen read waits for the registered RAM read; fill
// row and clear take one dispatch step, then one cell write per cycle (TEXT_COLS cells
// for fill, TEXT_ROWS*TEXT_COLS for clear); a print or newline that passes the bottom
// row adds a scroll (pipelined row-up copy, then bottom-row blanking). After reset a
// clearing pass over all TEXT_ROWS*TEXT_COLS cells (2000 at 80x25) fills the screen
// with spaces in attribute 0x0F while in_full stays high. cfg_text_attr, written with
// cfg_we while idle (a duty of the user; the block itself does not enforce it), is the
// attribute used by print, clear and scroll blanking.
module text_console_writer import tcw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [2:0] in_func,
  input  logic [7:0] in_char_code,
  input  logic [6:0] in_col,
  input  logic [4:0] in_row,
  input  logic [3:0] in_fg,
  input  logic [3:0] in_bg,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [6:0] out_cursor_x,
  output logic [4:0] out_cursor_y,
  output logic [7:0] out_cell_char,
  output logic [7:0] out_cell_attr,
  input  logic       cfg_we,
  input  logic [7:0] cfg_text_attr
);

  logic      cmd_valid;
  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  // Intake and classification
  tcw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_func      (in_func),
    .in_char_code (in_char_code),
    .in_col       (in_col),
    .in_row       (in_row),
    .in_fg        (in_fg),
    .in_bg        (in_bg),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .stat         (stat)
  );

  // Screen store and cursor execution
  tcw_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_text_attr (cfg_text_attr),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_cursor_x  (out_cursor_x),
    .out_cursor_y  (out_cursor_y),
    .out_cell_char (out_cell_char),
    .out_cell_attr (out_cell_attr)
  );

endmodule
